// File: hw/rtl/tfn_pkg.sv
package tfn_pkg;

	localparam int COORD_W   = 16;
	localparam int NFRAC     = 14;
	localparam int OUT_W     = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CROSS_W   = PROD_W + 1;
	localparam int NORM_TOP  = 30;
	localparam int M_W       = NORM_TOP + 1;
	localparam int EXT_W     = CROSS_W + M_W - 1;
	localparam int SH_W      = $clog2(CROSS_W);
	localparam int SQ_W      = 2 * M_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int Q_W       = NFRAC + 1;
	localparam int NUM_W     = M_W + NFRAC + 1;
	localparam int NST       = 6 + (ROOT_STEPS + 1) + (Q_W + 1) + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] az;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by_coord;
		logic signed [COORD_W-1:0] bz;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic                      last_triangle;
	} tri_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] nx;
		logic signed [OUT_W-1:0] ny;
		logic signed [OUT_W-1:0] nz;
		logic                    degenerate;
		logic                    last_normal;
	} nrm_t;

	typedef struct packed {
		logic [2:0][M_W-1:0] m;
		logic [2:0]          neg;
		logic                degen;
		logic                last;
	} tail_t;

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [SUM_W-1:0] res;
		tail_t            tl;
	} root_t;

	typedef struct packed {
		logic [2:0][NUM_W-1:0] num;
		logic [2:0][Q_W-1:0]   q;
		logic [ROOT_W-1:0]     r;
		logic [2:0]            neg;
		logic                  degen;
		logic                  last;
	} div_t;

endpackage

// File: hw/rtl/tfn_if.sv
interface tfn_tri_if import tfn_pkg::*;;
	logic valid;
	logic ready;
	tri_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tfn_nrm_if import tfn_pkg::*;;
	logic valid;
	logic ready;
	nrm_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/triangle_face_normal.sv
// Throughput: one triangle per cycle; the whole pipeline holds when the
// output register is full and not taken.
// The square root takes one result bit per stage and the division one
// quotient bit per stage, which sets the depth.
// Reset clears all valid bits at once; data registers are not reset.
module triangle_face_normal import tfn_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tfn_tri_if.sink    triangle,
	tfn_nrm_if.source  normal
);

	logic [NST-1:0] vld_q;
	logic           adv;

	logic signed [DIFF_W-1:0]  ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic                      last_s1;
	logic signed [PROD_W-1:0]  p_s2 [6];
	logic                      last_s2;
	logic signed [CROSS_W-1:0] cr [3];
	logic [CROSS_W-1:0]        mag_s3 [3];
	logic [2:0]                neg_s3;
	logic                      last_s3;
	logic [CROSS_W-1:0]        or_all;
	logic [SH_W-1:0]           top;
	logic [CROSS_W-1:0]        mag_s4 [3];
	logic [SH_W-1:0]           sh_s4;
	logic [2:0]                neg_s4;
	logic                      degen_s4, last_s4;
	logic [EXT_W-1:0]          shifted [3];
	tail_t                     tl_s5, tl_s6;
	logic [SQ_W-1:0]           sq_s6 [3];
	root_t                     rt_s [ROOT_STEPS+1];
	div_t                      dv_s [Q_W+1];
	logic [ROOT_W-1:0]         r_fix;
	nrm_t                      out_s;

	assign adv            = !vld_q[NST-1] || normal.ready;
	assign triangle.ready = adv;
	assign normal.valid   = vld_q[NST-1];
	assign normal.data    = out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], triangle.valid};
		end
	end

	always_comb begin
		cr[0] = CROSS_W'(p_s2[0]) - CROSS_W'(p_s2[1]);
		cr[1] = CROSS_W'(p_s2[2]) - CROSS_W'(p_s2[3]);
		cr[2] = CROSS_W'(p_s2[4]) - CROSS_W'(p_s2[5]);
		or_all = mag_s3[0] | mag_s3[1] | mag_s3[2];
		top = '0;
		for (int i = 0; i < CROSS_W; i++) begin
			if (or_all[i]) begin
				top = SH_W'(i);
			end
		end
		for (int i = 0; i < 3; i++) begin
			shifted[i] = {mag_s4[i], {(M_W-1){1'b0}}} << sh_s4;
		end
		r_fix = rt_s[ROOT_STEPS].res[ROOT_W-1:0];
		if (r_fix == '0) begin
			r_fix = ROOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s1   <= DIFF_W'(triangle.data.bx) - DIFF_W'(triangle.data.ax);
			uy_s1   <= DIFF_W'(triangle.data.by_coord) - DIFF_W'(triangle.data.ay);
			uz_s1   <= DIFF_W'(triangle.data.bz) - DIFF_W'(triangle.data.az);
			vx_s1   <= DIFF_W'(triangle.data.cx) - DIFF_W'(triangle.data.ax);
			vy_s1   <= DIFF_W'(triangle.data.cy) - DIFF_W'(triangle.data.ay);
			vz_s1   <= DIFF_W'(triangle.data.cz) - DIFF_W'(triangle.data.az);
			last_s1 <= triangle.data.last_triangle;

			p_s2[0] <= PROD_W'(uy_s1) * PROD_W'(vz_s1);
			p_s2[1] <= PROD_W'(uz_s1) * PROD_W'(vy_s1);
			p_s2[2] <= PROD_W'(uz_s1) * PROD_W'(vx_s1);
			p_s2[3] <= PROD_W'(ux_s1) * PROD_W'(vz_s1);
			p_s2[4] <= PROD_W'(ux_s1) * PROD_W'(vy_s1);
			p_s2[5] <= PROD_W'(uy_s1) * PROD_W'(vx_s1);
			last_s2 <= last_s1;

			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= cr[i][CROSS_W-1];
				mag_s3[i] <= cr[i][CROSS_W-1] ? -cr[i] : cr[i];
			end
			last_s3 <= last_s2;

			mag_s4   <= mag_s3;
			sh_s4    <= SH_W'(CROSS_W - 1) - top;
			neg_s4   <= neg_s3;
			degen_s4 <= (or_all == '0);
			last_s4  <= last_s3;

			for (int i = 0; i < 3; i++) begin
				tl_s5.m[i] <= shifted[i][EXT_W-1 -: M_W];
			end
			tl_s5.neg   <= neg_s4;
			tl_s5.degen <= degen_s4;
			tl_s5.last  <= last_s4;

			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= SQ_W'(tl_s5.m[i]) * SQ_W'(tl_s5.m[i]);
			end
			tl_s6 <= tl_s5;

			rt_s[0].rem <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
			rt_s[0].res <= '0;
			rt_s[0].tl  <= tl_s6;

			for (int i = 0; i < 3; i++) begin
				dv_s[0].num[i] <= {1'b0, rt_s[ROOT_STEPS].tl.m[i], {NFRAC{1'b0}}}
					+ NUM_W'(r_fix >> 1);
				dv_s[0].q[i] <= '0;
			end
			dv_s[0].r     <= r_fix;
			dv_s[0].neg   <= rt_s[ROOT_STEPS].tl.neg;
			dv_s[0].degen <= rt_s[ROOT_STEPS].tl.degen;
			dv_s[0].last  <= rt_s[ROOT_STEPS].tl.last;

			out_s.nx <= dv_s[Q_W].neg[0] ? -OUT_W'(dv_s[Q_W].q[0]) : OUT_W'(dv_s[Q_W].q[0]);
			out_s.ny <= dv_s[Q_W].neg[1] ? -OUT_W'(dv_s[Q_W].q[1]) : OUT_W'(dv_s[Q_W].q[1]);
			out_s.nz <= dv_s[Q_W].neg[2] ? -OUT_W'(dv_s[Q_W].q[2]) : OUT_W'(dv_s[Q_W].q[2]);
			out_s.degenerate  <= dv_s[Q_W].degen;
			out_s.last_normal <= dv_s[Q_W].last;
		end
	end

	for (genvar k = 1; k <= ROOT_STEPS; k++) begin : g_root
		logic [SUM_W-1:0] bit_w, trial;
		assign bit_w = SUM_W'(1) << (SUM_W - 2 * k);
		assign trial = rt_s[k-1].res + bit_w;
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_s[k].tl <= rt_s[k-1].tl;
				if (rt_s[k-1].rem >= trial) begin
					rt_s[k].rem <= rt_s[k-1].rem - trial;
					rt_s[k].res <= (rt_s[k-1].res >> 1) + bit_w;
				end else begin
					rt_s[k].rem <= rt_s[k-1].rem;
					rt_s[k].res <= rt_s[k-1].res >> 1;
				end
			end
		end
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_div
		logic [NUM_W-1:0] trial;
		assign trial = NUM_W'(dv_s[j-1].r) << (Q_W - j);
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j].r     <= dv_s[j-1].r;
				dv_s[j].neg   <= dv_s[j-1].neg;
				dv_s[j].degen <= dv_s[j-1].degen;
				dv_s[j].last  <= dv_s[j-1].last;
				for (int i = 0; i < 3; i++) begin
					if (dv_s[j-1].num[i] >= trial) begin
						dv_s[j].num[i] <= dv_s[j-1].num[i] - trial;
						dv_s[j].q[i]   <= dv_s[j-1].q[i] | (Q_W'(1) << (Q_W - j));
					end else begin
						dv_s[j].num[i] <= dv_s[j-1].num[i];
						dv_s[j].q[i]   <= dv_s[j-1].q[i];
					end
				end
			end
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		normal.valid && normal.data.degenerate |->
			normal.data.nx == '0 && normal.data.ny == '0 && normal.data.nz == '0)
		else $error("degenerate normal has a nonzero component");

	a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		normal.valid && !normal.data.degenerate |->
			normal.data.nx != '0 || normal.data.ny != '0 || normal.data.nz != '0)
		else $error("normal of a proper triangle is zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!triangle.ready |-> normal.valid && !normal.ready)
		else $error("input held off while output is free");

endmodule
